### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the allocator RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define BRA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define BRA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### sv/bra_pkg.sv
// ---------------------------------------------------------------------------
// bra_pkg
// Types, codes and helpers of the bitmap run allocator.
// ---------------------------------------------------------------------------
package bra_pkg;

   localparam int BPC    = 32;            // blocks per chunk
   localparam int POS_W  = 5;             // bit position within a chunk
   localparam int LEN_W  = 6;             // run length, 0..BPC
   localparam int WORD_W = 2 * BPC;       // {run_end, used}

   typedef enum logic [1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_FREE   = 2'd1,
      MODE_RESIZE = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_BAD_SIZE  = 3'd1;
   localparam logic [2:0] STAT_NO_SPACE  = 3'd2;
   localparam logic [2:0] STAT_BAD_ADDR  = 3'd3;
   localparam logic [2:0] STAT_NOT_ALLOC = 3'd4;
   localparam logic [2:0] STAT_NO_FIT    = 3'd5;

   localparam logic CSR_STEP_SHIFT = 1'b0;
   localparam logic CSR_CHUNKS     = 1'b1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SEARCH,
      S_FREVAL,
      S_WRITE
   } state_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;
   } fit_res_type;

   // mask of n low ones, n in 0..BPC
   function automatic logic [BPC-1:0] run_mask(input logic [LEN_W-1:0] n);
      logic [BPC-1:0] m;
      if (n >= LEN_W'(BPC)) m = '1;
      else                  m = (BPC'(1) << n) - BPC'(1);
      return m;
   endfunction

endpackage

### sv/bra_fit.sv
// ---------------------------------------------------------------------------
// bra_fit
// First-fit search of one chunk's used map for a free run of given length.
// ---------------------------------------------------------------------------
module bra_fit
   import bra_pkg::*;
(
   input  logic [BPC-1:0]   word_used,
   input  logic [LEN_W-1:0] run_len,
   output fit_res_type      fit
);

   logic [BPC-1:0] free_bits;
   logic [BPC-1:0] mask;
   logic [BPC-1:0] hit;

   assign free_bits = ~word_used;
   assign mask      = run_mask(run_len);

   // every start position tested on its own
   always_comb begin
      for (int p = 0; p < BPC; p++) begin
         hit[p] = (((free_bits >> p) & mask) == mask) &&
                  ((p + int'(run_len)) <= BPC) && (run_len != '0);
      end
   end

   // lowest hit wins
   always_comb begin
      fit.found = |hit;
      fit.pos   = '0;
      for (int p = BPC - 1; p >= 0; p--) begin
         if (hit[p]) begin
            fit.pos = POS_W'(p);
         end
      end
   end

endmodule

### sv/bitmap_run_allocator_core.sv
// ---------------------------------------------------------------------------
// bitmap_run_allocator_core
// First-fit run allocator over a pool of chunk bitmaps kept in one memory.
// ---------------------------------------------------------------------------
// Alloc: decode, a read of the predicted chunk if valid, then a scan at one read
//   per cycle until a chunk fits (then a write) or no room is left.
// Free: decode, evaluate, write. Resize check and free errors end at evaluate;
// bad size, full or bad address at decode. Clear: one memory row zeroed per cycle.
// One request at a time; next start taken while rsp_valid pulses; no stall.
// Reset: a clearing pass runs with busy high, no response.
module bitmap_run_allocator_core
   import bra_pkg::*;
#(
   parameter int NUM_CHUNKS = 64
)
(
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [11:0] req_request_bytes,
   input  logic [17:0] req_block_offset,
   // response
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [16:0] rsp_result_offset,
   output logic [5:0]  rsp_size_blocks,
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);

`include "assert_macros.svh"

   localparam int CW  = $clog2(NUM_CHUNKS);        // chunk address
   localparam int CNW = $clog2(NUM_CHUNKS + 1);    // chunk count / predictor

   // ---------------- configuration ----------------
   logic [2:0] step_ff;
   logic [6:0] chunks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= 3'd4;
         chunks_ff <= 7'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_SHIFT: step_ff   <= csr_wdata[2:0];
            CSR_CHUNKS:     chunks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [2:0]     sh;      // effective log2 block size
   logic [CNW-1:0] maxn;    // effective chunk count

   always_comb begin
      if (step_ff < 3'd4)      sh = 3'd4;
      else if (step_ff > 3'd6) sh = 3'd6;
      else                     sh = step_ff;
      if (32'(chunks_ff) > NUM_CHUNKS) maxn = CNW'(NUM_CHUNKS);
      else                             maxn = CNW'(chunks_ff);
   end

   // ---------------- pool memory: {run_end, used} per chunk ----------------
   logic [WORD_W-1:0] mem [NUM_CHUNKS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we;
   logic              mem_re;
   logic [CW-1:0]     mem_wa;
   logic [CW-1:0]     mem_ra;
   logic [WORD_W-1:0] mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   // ---------------- control and datapath registers ----------------
   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [11:0]       req_ff, req_in;
   logic [17:0]       off_ff, off_in;
   logic [LEN_W-1:0]  len_ff, len_in;         // alloc run length
   logic [CW-1:0]     chunk_ff, chunk_in;     // free / resize chunk
   logic [POS_W-1:0]  bit_ff, bit_in;         // free / resize block in chunk
   logic [CW:0]       issue_ff, issue_in;     // next chunk to read in scan
   logic              pend_ff, pend_in;       // read data in flight
   logic [CW-1:0]     pchk_ff, pchk_in;       // chunk of that read
   logic [CW-1:0]     clr_ff, clr_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic              full_ff, full_in;
   logic [CNW-1:0]    pred_ff [BPC];
   logic [CW-1:0]     wr_addr_ff, wr_addr_in;
   logic [WORD_W-1:0] wr_data_ff, wr_data_in;
   logic [2:0]        res_status_ff, res_status_in;
   logic [16:0]       res_offset_ff, res_offset_in;
   logic [5:0]        res_size_ff, res_size_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [16:0]       rsp_offset_ff, rsp_offset_in;
   logic [5:0]        rsp_size_ff, rsp_size_in;

   logic              pred_clr;
   logic              pred_we;
   logic [POS_W-1:0]  pred_idx;
   logic [CNW-1:0]    pred_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         full_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < BPC; i++) pred_ff[i] <= CNW'(i + 1);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         full_ff      <= full_in;
         pend_ff      <= pend_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pred_clr) begin
            for (int i = 0; i < BPC; i++) pred_ff[i] <= CNW'(i + 1);
         end else if (pred_we) begin
            pred_ff[pred_idx] <= pred_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      req_ff        <= req_in;
      off_ff        <= off_in;
      len_ff        <= len_in;
      chunk_ff      <= chunk_in;
      bit_ff        <= bit_in;
      pchk_ff       <= pchk_in;
      wr_addr_ff    <= wr_addr_in;
      wr_data_ff    <= wr_data_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      res_size_ff   <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_size_ff   <= rsp_size_in;
   end

   // ---------------- first-fit unit on the read data ----------------
   fit_res_type fit;

   bra_fit u_fit (
      .word_used (rd_data_ff[BPC-1:0]),
      .run_len   (len_ff),
      .fit       (fit)
   );

   // ---------------- decode helpers ----------------
   logic [12:0]      req_round;      // request + block - 1
   logic [8:0]       req_blocks;     // request in blocks
   logic             size_bad;
   logic [CNW-1:0]   pred_c;
   logic             pred_ok;
   logic [31:0]      limit;
   logic             addr_bad;

   assign req_round  = 13'(req_ff) + ((13'(1) << sh) - 13'(1));
   assign req_blocks = 9'(req_round >> sh);
   assign size_bad   = (req_ff == '0) || (13'(req_ff) > (13'(BPC) << sh));
   assign pred_c     = pred_ff[POS_W'(req_blocks - 9'd1)];
   assign pred_ok    = (pred_c != '0) && (pred_c <= maxn);
   assign limit      = 32'(maxn) << (4'(sh) + 4'd5);
   assign addr_bad   = (32'(off_ff) >= limit) ||
                       ((off_ff & ((18'(1) << sh) - 18'(1))) != '0);

   // ---------------- free / resize evaluation helpers ----------------
   logic [BPC-1:0]   ev_used;
   logic [BPC-1:0]   ev_ends;
   logic [BPC-1:0]   ends_sh;
   logic [LEN_W-1:0] run_n;          // run length to the next run end
   logic [BPC-1:0]   run_bits;

   assign ev_used  = rd_data_ff[BPC-1:0];
   assign ev_ends  = rd_data_ff[WORD_W-1:BPC];
   assign ends_sh  = ev_ends >> bit_ff;
   assign run_bits = run_mask(run_n) << bit_ff;

   always_comb begin
      run_n = '0;
      for (int p = BPC - 1; p >= 0; p--) begin
         if (ends_sh[p]) run_n = LEN_W'(p + 1);
      end
   end

   // ---------------- alloc placement helpers ----------------
   logic [BPC-1:0]   place_used;
   logic [BPC-1:0]   place_ends;
   logic [CNW-1:0]   place_pred;
   logic [CNW:0]     pred_adv;
   logic [16:0]      place_off;

   assign place_used = ev_used | (run_mask(len_ff) << fit.pos);
   assign place_ends = ev_ends | (BPC'(1) << (6'(fit.pos) + len_ff - 6'd1));
   assign pred_adv   = (CNW + 1)'(pchk_ff) + (CNW + 1)'(1 + BPC);
   always_comb begin
      // advance the predictor when no second run of this length fits after
      if ((7'(fit.pos) + 7'(len_ff) + 7'(len_ff)) > 7'(BPC)) begin
         if (pred_adv <= (CNW + 1)'(maxn)) place_pred = CNW'(pred_adv);
         else                              place_pred = '0;
      end else begin
         place_pred = CNW'(pchk_ff) + CNW'(1);
      end
   end
   assign place_off = 17'(({21'(pchk_ff), fit.pos}) << sh);

   // ---------------- state machine ----------------
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      req_in        = req_ff;
      off_in        = off_ff;
      len_in        = len_ff;
      chunk_in      = chunk_ff;
      bit_in        = bit_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      pchk_in       = pchk_ff;
      clr_in        = clr_ff;
      clr_rsp_in    = clr_rsp_ff;
      full_in       = full_ff;
      wr_addr_in    = wr_addr_ff;
      wr_data_in    = wr_data_ff;
      res_status_in = res_status_ff;
      res_offset_in = res_offset_ff;
      res_size_in   = res_size_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_size_in   = rsp_size_ff;
      pred_clr      = 1'b0;
      pred_we       = 1'b0;
      pred_idx      = '0;
      pred_val      = '0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_wa        = '0;
      mem_ra        = '0;
      mem_wd        = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // zero one row per cycle
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(NUM_CHUNKS - 1)) begin
               clr_in        = '0;
               state_in      = S_IDLE;
               rsp_valid_in  = clr_rsp_ff;
               rsp_status_in = STAT_OK;
               rsp_offset_in = '0;
               rsp_size_in   = '0;
               clr_rsp_in    = 1'b0;
            end
         end

         S_IDLE: begin
            if (start) begin
               mode_in  = mode_type'(req_mode);
               req_in   = req_request_bytes;
               off_in   = req_block_offset;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            rsp_status_in = STAT_OK;
            rsp_offset_in = '0;
            rsp_size_in   = '0;
            unique case (mode_ff)
               MODE_ALLOC: begin
                  len_in   = 6'(req_blocks);
                  issue_in = '0;
                  if (size_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_BAD_SIZE;
                     state_in      = S_IDLE;
                  end else if (full_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_NO_SPACE;
                     state_in      = S_IDLE;
                  end else begin
                     // try the predicted chunk first
                     if (pred_ok) begin
                        mem_re  = 1'b1;
                        mem_ra  = CW'(pred_c - CNW'(1));
                        pend_in = 1'b1;
                        pchk_in = CW'(pred_c - CNW'(1));
                     end
                     state_in = S_SEARCH;
                  end
               end
               MODE_FREE, MODE_RESIZE: begin
                  chunk_in = CW'(off_ff >> (4'(sh) + 4'd5));
                  bit_in   = POS_W'(off_ff >> sh);
                  if (addr_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_BAD_ADDR;
                     state_in      = S_IDLE;
                  end else begin
                     mem_re   = 1'b1;
                     mem_ra   = CW'(off_ff >> (4'(sh) + 4'd5));
                     state_in = S_FREVAL;
                  end
               end
               MODE_CLEAR: begin
                  pred_clr   = 1'b1;
                  full_in    = 1'b0;
                  clr_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = S_CLEAR;
               end
               default: state_in = S_IDLE;
            endcase
         end

         S_SEARCH: begin
            // evaluate the pending chunk while the next read is issued
            if (pend_ff && fit.found) begin
               wr_addr_in    = pchk_ff;
               wr_data_in    = {place_ends, place_used};
               pred_we       = 1'b1;
               pred_idx      = POS_W'(len_ff - 6'd1);
               pred_val      = place_pred;
               res_status_in = STAT_OK;
               res_offset_in = place_off;
               res_size_in   = '0;
               state_in      = S_WRITE;
            end else if (32'(issue_ff) < 32'(maxn)) begin
               mem_re   = 1'b1;
               mem_ra   = CW'(issue_ff);
               pend_in  = 1'b1;
               pchk_in  = CW'(issue_ff);
               issue_in = issue_ff + (CW + 1)'(1);
            end else if (!pend_ff) begin
               full_in       = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_NO_SPACE;
               rsp_offset_in = '0;
               rsp_size_in   = '0;
               state_in      = S_IDLE;
            end
         end

         S_FREVAL: begin
            rsp_status_in = STAT_OK;
            rsp_offset_in = '0;
            rsp_size_in   = '0;
            if (ends_sh == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_NOT_ALLOC;
               state_in      = S_IDLE;
            end else if (mode_ff == MODE_RESIZE) begin
               rsp_valid_in = 1'b1;
               rsp_size_in  = run_n;
               if (req_blocks <= 9'(run_n)) rsp_offset_in = off_ff[16:0];
               else                         rsp_status_in = STAT_NO_FIT;
               state_in = S_IDLE;
            end else if ((ev_used & run_bits) != run_bits) begin
               // double free
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_NOT_ALLOC;
               state_in      = S_IDLE;
            end else begin
               wr_addr_in    = chunk_ff;
               wr_data_in    = {ev_ends & ~(BPC'(1) << (6'(bit_ff) + run_n - 6'd1)),
                                ev_used & ~run_bits};
               pred_we       = 1'b1;
               pred_idx      = POS_W'(run_n - 6'd1);
               pred_val      = CNW'(chunk_ff) + CNW'(1);
               if ((ev_used & ~run_bits) == '0) full_in = 1'b0;
               res_status_in = STAT_OK;
               res_offset_in = '0;
               res_size_in   = '0;
               state_in      = S_WRITE;
            end
         end

         S_WRITE: begin
            mem_we        = 1'b1;
            mem_wa        = wr_addr_ff;
            mem_wd        = wr_data_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status_ff;
            rsp_offset_in = res_offset_ff;
            rsp_size_in   = res_size_ff;
            state_in      = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_offset = rsp_offset_ff;
   assign rsp_size_blocks   = rsp_size_ff;

   // ---------------- assertions ----------------
   `BRA_ASSERT(a_rsp_after_busy, rsp_valid_ff |-> $past(busy), "response without request")
   `BRA_ASSERT_ALWAYS(a_one_port, !(mem_we && mem_re), "memory read and write collide")
   `BRA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not go busy")
   `BRA_ASSERT(a_scan_bound, 32'(issue_ff) <= NUM_CHUNKS, "scan ran past the pool")

endmodule
